// ===== rtl/skti_pkg.sv =====
// Shared constants and codes for the sorted key table.
`default_nettype none

package skti_pkg;

    // Default sizing, handed to the top level parameters
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 16;

    // Fixed port widths
    localparam int KEY_W  = 16;
    localparam int POS_W  = 9;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/skti_cell.sv =====
// One table slot: holds a key, compares it against the search key, shifts on insert.
`default_nettype none

module skti_cell import skti_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int CNT_W    = 9,
    parameter int IDX      = 0
) (
    input  wire logic                i_clk,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [CNT_W-1:0]    i_count,
    input  wire logic                i_left_lt,
    input  wire logic [KEY_BITS-1:0] i_left_key,
    input  wire logic                i_cmp,
    input  wire logic                i_ins,
    output logic      [KEY_BITS-1:0] o_key,
    output logic                     o_lt,
    output logic                     o_eq,
    output logic                     o_bnd
);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_lt, n_lt;
    logic                r_eq, n_eq;
    logic                occupied;

    assign occupied = (CNT_W'(IDX) < i_count);

    always_comb begin
        n_lt  = r_lt;
        n_eq  = r_eq;
        n_key = r_key;
        if (i_cmp) begin
            n_lt = occupied && (r_key < i_key);
            n_eq = occupied && (r_key == i_key);
        end
        // slots at or past the insertion point take the new key or the left neighbor's
        if (i_ins && !r_lt) begin
            n_key = i_left_lt ? i_key : i_left_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lt  <= n_lt;
        r_eq  <= n_eq;
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_bnd = i_left_lt && !r_lt;

endmodule

`default_nettype wire

// ===== rtl/skti_enc.sv =====
// Turns the one-hot boundary flags of the cell row into a position and a hit flag.
`default_nettype none

module skti_enc import skti_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = 9
) (
    input  wire logic [CAPACITY-1:0] i_bnd,
    input  wire logic [CAPACITY-1:0] i_eq,
    input  wire logic                i_all_lt,
    output logic      [CNT_W-1:0]    o_pos,
    output logic                     o_found
);

    logic [CNT_W-1:0] pos_or;
    logic             hit;

    always_comb begin
        pos_or = '0;
        hit    = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_bnd[i]) begin
                pos_or = pos_or | CNT_W'(i);
            end
            hit = hit | (i_bnd[i] & i_eq[i]);
        end
    end

    // no boundary at all: every slot holds a smaller key, so the point is the end
    assign o_pos   = i_all_lt ? CNT_W'(CAPACITY) : pos_or;
    assign o_found = hit;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_table_insert_lookup.sv =====
// Top level of the sorted key table: control sequence, cell row and result register.
`default_nettype none

// Sorted key table with lookup and insert. Keys sit in a row of CAPACITY cells,
// cell i holding the i-th smallest key; only the first entry_count cells are
// occupied. After its word is accepted, a result reaches the output register in
// steps: the acceptance edge captures the word, then every cell compares its key
// with the search key in parallel, the cell row's boundary is encoded into a
// position, an insert is applied (all cells from the insertion point on shift
// up by one together, the boundary cell loading the new key), and the result is
// handed to the output register. The input side stalls during reset and while a
// word is in progress, so a new word is accepted only once the last one's result
// has gone to the output register; a stalled output register holds the sequence
// in its last step and stretches that by the length of the stall.
// The output register lets a finished result wait while the next word is
// accepted. Status: 0 found or inserted, 1 not found, 2 duplicate key, 3 table
// full (the duplicate check wins). position is the key's index or its sorted
// insertion point, and entry_count is the number of keys held after the word.
// Only the low KEY_BITS bits of the key take part. Slot contents need no
// clearing after reset since unoccupied slots never report a match.

module sorted_key_table_insert_lookup import skti_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_command,
    input  wire logic [KEY_W-1:0]  i_key,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [STAT_W-1:0] o_status,
    output logic      [POS_W-1:0]  o_position,
    output logic      [POS_W-1:0]  o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KIN   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_ENC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // captured word and sequence results
    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_pos;
    logic                r_found;
    logic [STAT_W-1:0]   r_status, n_status;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [POS_W-1:0]    r_out_pos;
    logic [POS_W-1:0]    r_out_count;

    logic in_take;
    logic out_load;
    logic do_ins;
    logic cell_cmp;
    logic cell_ins;

    // cell row wiring
    logic [KEY_BITS-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_bnd;
    logic [CNT_W-1:0]    enc_pos;
    logic                enc_found;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign cell_cmp = (r_state == S_CMP);

    // an insert goes ahead only for an absent key with room left
    assign do_ins   = (r_cmd == CMD_INSERT) && !r_found && (r_count < CNT_W'(CAPACITY));
    assign cell_ins = (r_state == S_UPD) && do_ins;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_take) begin
                n_state = S_CMP;
            end
            S_CMP:  n_state = S_ENC;
            S_ENC:  n_state = S_UPD;
            S_UPD:  n_state = S_DONE;
            S_DONE: if (out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        if (r_state == S_UPD) begin
            priority if (r_cmd == CMD_LOOKUP) begin
                n_status = r_found ? ST_OK : ST_MISS;
            end else if (r_found) begin
                n_status = ST_DUP;
            end else if (!do_ins) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_OK;
                n_count  = r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: capture the word, hold encode results, load the output register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_command;
            r_key <= KEY_BITS'(i_key[KIN-1:0]);
        end
        if (r_state == S_ENC) begin
            r_pos   <= enc_pos;
            r_found <= enc_found;
        end
        r_status <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_pos    <= POS_W'(r_pos);
            r_out_count  <= POS_W'(r_count);
        end
    end

    // row of cells; each takes the left neighbor's key when an insert shifts
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                left_lt;
        logic [KEY_BITS-1:0] left_key;

        if (g == 0) begin : g_head
            assign left_lt  = 1'b1;
            assign left_key = r_key;
        end else begin : g_body
            assign left_lt  = w_lt[g-1];
            assign left_key = w_key[g-1];
        end

        skti_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_key      (r_key),
            .i_count    (r_count),
            .i_left_lt  (left_lt),
            .i_left_key (left_key),
            .i_cmp      (cell_cmp),
            .i_ins      (cell_ins),
            .o_key      (w_key[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g]),
            .o_bnd      (w_bnd[g])
        );
    end

    skti_enc #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_enc (
        .i_bnd    (w_bnd),
        .i_eq     (w_eq),
        .i_all_lt (w_lt[CAPACITY-1]),
        .o_pos    (enc_pos),
        .o_found  (enc_found)
    );

    // hold the input side off during reset and while a word is in progress
    assign o_in_stall    = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

// ===== dv/tb_sorted_key_table_insert_lookup.sv =====
// Testbench for the sorted key table: self-checking lookups and inserts under random idling.
`default_nettype none

module tb_sorted_key_table_insert_lookup import skti_pkg::*;;

    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_BITS_DEF{1'b1}};
    // Upper bound on the run, allowing several times the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    // Settling margin after the block presents its last result.
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  entry_count;
    } t_table_result;

    // Holds its own sorted copy of the keys and the results still owed by the block.
    class t_sorted_table_scoreboard;
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        int               used;
        int               errors;
        t_table_result    owed_results [$];

        function new();
            used   = 0;
            errors = 0;
        endfunction

        // Binary search over the occupied slots; where gets the index or the insertion point.
        function bit find_slot(input logic [KEY_W-1:0] key, output int where);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = used;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (key < keys[mid]) begin
                    hi = mid;
                end else if (key > keys[mid]) begin
                    lo = mid + 1;
                end else begin
                    where = mid;
                    return 1'b1;
                end
            end
            where = lo;
            return 1'b0;
        endfunction

        function void note_word(input logic cmd, input logic [KEY_W-1:0] key_in);
            logic [KEY_W-1:0] key;
            t_table_result    res;
            bit               found;
            int               where;
            int               i;
            key   = key_in & KEY_MASK;
            found = find_slot(key, where);
            res.position = POS_W'(where);
            if (cmd == CMD_LOOKUP) begin
                res.status = found ? ST_OK : ST_MISS;
            end else if (found) begin
                res.status = ST_DUP;
            end else if (used >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                for (i = used; i > where; i--) begin
                    keys[i] = keys[i - 1];
                end
                keys[where] = key;
                used++;
                res.status = ST_OK;
            end
            res.entry_count = POS_W'(used);
            owed_results.push_back(res);
        endfunction

        function void check_result(input logic [STAT_W-1:0] status,
                                   input logic [POS_W-1:0]  position,
                                   input logic [POS_W-1:0]  entry_count);
            t_table_result exp_res;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result status %0d position %0d count %0d",
                         $time, status, position, entry_count);
                errors++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_res.status, status);
                errors++;
            end
            if (position !== exp_res.position) begin
                $display("%0t: position expected %0d actual %0d",
                         $time, exp_res.position, position);
                errors++;
            end
            if (entry_count !== exp_res.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, exp_res.entry_count, entry_count);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_command   = CMD_LOOKUP;
    logic [KEY_W-1:0]  i_key       = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [STAT_W-1:0] o_status;
    logic [POS_W-1:0]  o_position;
    logic [POS_W-1:0]  o_entry_count;

    t_sorted_table_scoreboard table_sb;

    // Percent chance of an idle burst before each word / at each edge on the result side.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;
    int cycle_count   = 0;

    sorted_key_table_insert_lookup u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, table_sb.owed_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check every result taken, then decide the stall for the next edge.
    // Once started, a stall burst runs out even if idling is switched off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                table_sb.check_result(o_status, o_position, o_entry_count);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= stall_left - 1;
            end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 8);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Present one word and hold it until the block takes it. Called at a rising edge,
    // returns at the edge of acceptance. An idle burst lowers valid first; without one,
    // valid stays high from word to word, so it gets a single assignment per edge.
    task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        table_sb.note_word(cmd, key);
    endtask

    // Hold off the sender until every owed result is back, then rest before going on.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (table_sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Favor keys already held and their neighbors, so that hits, duplicates and
    // mid-table inserts are common; mix in the field extremes and plain random keys.
    function automatic logic [KEY_W-1:0] pick_key(input logic cmd);
        logic [KEY_W-1:0] key;
        int               roll;
        int               held;
        held = table_sb.used;
        roll = $urandom_range(0, 99);
        if (held > 0 && roll < 35) begin
            key = table_sb.keys[$urandom_range(0, held - 1)];
        end else if (held > 0 && roll < 50) begin
            key = table_sb.keys[$urandom_range(0, held - 1)];
            key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
        end else if (roll < 58) begin
            case ($urandom_range(0, 5))
                0:       key = '0;
                1:       key = 16'h0001;
                2:       key = '1;
                3:       key = 16'hFFFE;
                4:       key = 16'h8000;
                default: key = 16'h7FFF;
            endcase
        end else begin
            key = KEY_W'($urandom);
        end
        // Keep the top key out of the table, so a full table still has an
        // insertion point past its last slot.
        if (cmd == CMD_INSERT && key == '1 && held < TABLE_DEPTH) begin
            key = key - 1'b1;
        end
        return key;
    endfunction

    task automatic run_random_words(input int count, input int insert_pct);
        logic cmd;
        int   n;
        for (n = 0; n < count; n++) begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP;
            send_word(cmd, pick_key(cmd));
        end
    endtask

    initial begin
        table_sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: empty table, front / middle / end inserts, duplicates, hits and misses.
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_word(CMD_LOOKUP, 16'h0000);   // miss on an empty table
        send_word(CMD_LOOKUP, 16'hFFFF);
        send_word(CMD_INSERT, 16'h8000);   // first key
        send_word(CMD_INSERT, 16'h0000);   // insert at the front, shift up
        send_word(CMD_INSERT, 16'hFFFE);   // append at the end
        send_word(CMD_INSERT, 16'h8000);   // duplicate
        send_word(CMD_INSERT, 16'h7FFF);   // insert in the middle
        send_word(CMD_LOOKUP, 16'h0000);   // hit on the first slot
        send_word(CMD_LOOKUP, 16'hFFFE);   // hit on the last slot
        send_word(CMD_LOOKUP, 16'hFFFF);   // miss past the end
        send_word(CMD_LOOKUP, 16'h8001);   // miss in the middle
        send_word(CMD_LOOKUP, 16'h7FFF);
        send_word(CMD_INSERT, 16'h0000);   // duplicate at the front
        send_word(CMD_INSERT, 16'h0001);
        send_word(CMD_INSERT, 16'hAAAA);
        send_word(CMD_LOOKUP, 16'hAAAA);
        send_word(CMD_INSERT, 16'h5555);
        send_word(CMD_LOOKUP, 16'h5554);
        send_word(CMD_INSERT, 16'hFFFE);   // duplicate at the end
        send_word(CMD_LOOKUP, 16'h0001);
        wait_results_drained();

        // Random words. Lookup-heavy start with idling on both sides.
        send_idle_pct = 30;
        recv_idle_pct = 30;
        run_random_words(600, 25);
        // Insert-heavy stretch that fills the table; back-to-back words into a stalling sink.
        send_idle_pct = 0;
        recv_idle_pct = 50;
        run_random_words(500, 65);
        // Full table: refused inserts and lookups, sender idling only.
        send_idle_pct = 50;
        recv_idle_pct = 0;
        run_random_words(300, 40);
        wait_results_drained();
        // Closing stretch at full rate, no idling anywhere.
        send_idle_pct = 0;
        run_random_words(300, 40);

        i_in_valid <= 1'b0;
        while (table_sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (table_sb.owed_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, table_sb.owed_results.size());
        end
        if (table_sb.errors == 0 && table_sb.owed_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
